// File: design/afc_pkg.sv
// afc_pkg: shared types, constants and the byte-wide CRC-16 update for adts_frame_crc16.
// No dependencies.
`default_nettype none

package afc_pkg;

  localparam logic [15:0] CrcPoly    = 16'h8005;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [7:0]  SyncByte   = 8'hFF;
  localparam logic [7:0]  HiNibMask  = 8'hF0;
  localparam logic [7:0]  ProtAbsBit = 8'h01;
  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] PosFirst  = 4'd0;
  localparam logic [PosW-1:0] PosSecond = 4'd1;
  localparam logic [PosW-1:0] PosGapLo  = 4'd7;
  localparam logic [PosW-1:0] PosGapHi  = 4'd8;
  localparam logic [PosW-1:0] PosSat    = 4'd9;

  typedef struct packed {
    logic [15:0] crc;
    logic        skipped;
  } afc_res_t;

  // MSB-first CRC-16 over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/adts_frame_crc16_top.sv
// adts_frame_crc16_top: input register, CRC core and result register with valid/ready.
// Depends on afc_pkg and afc_core.
//
//   channel | direction | payload                         | handshake
//   in      | request   | data_byte_i, last_byte_i        | in_valid_i / in_ready_o
//   out     | result    | crc_value_o, field_skipped_o    | out_valid_o / out_ready_i
//
// One byte per cycle while no held result stalls a last byte; a result becomes valid
// once its last byte has passed the input register and then the result register.
// The byte-wide CRC update in afc_core sits between the two registers.
// A held result stalls only last bytes; other bytes keep flowing past it.
// Reset clears frame state; the first request may follow right after reset.
`default_nettype none

module adts_frame_crc16_top
  import afc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      crc_value_o,
  output logic             field_skipped_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       step;
  logic       out_valid_q;
  afc_res_t   res, res_q;

  assign step       = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  afc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (step && last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign crc_value_o     = res_q.crc;
  assign field_skipped_o = res_q.skipped;

endmodule

`default_nettype wire

// File: design/afc_core.sv
// afc_core: frame state (byte position, header match) and the two running CRCs.
// Depends on afc_pkg. State advances on step_i; result is combinational from the current byte.
`default_nettype none

module afc_core
  import afc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic     last_byte_i,
  output afc_res_t      res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_all_q, crc_all_d;
  logic [15:0]     crc_gap_q, crc_gap_d;
  logic            first_ff_q, first_ff_d;
  logic            field_q, field_d;
  logic            skipped;

  always_comb begin
    first_ff_d = first_ff_q;
    field_d    = field_q;
    if (pos_q == PosFirst) begin
      first_ff_d = (data_byte_i == SyncByte);
    end else if (pos_q == PosSecond) begin
      field_d = first_ff_q && ((data_byte_i & HiNibMask) == HiNibMask)
                && ((data_byte_i & ProtAbsBit) == 8'h00);
    end
    crc_all_d = crc16_byte(crc_all_q, data_byte_i);
    if (pos_q == PosGapLo || pos_q == PosGapHi) begin
      crc_gap_d = crc_gap_q;
    end else begin
      crc_gap_d = crc16_byte(crc_gap_q, data_byte_i);
    end
    pos_d   = (pos_q < PosSat) ? pos_q + 4'd1 : pos_q;
    skipped = field_d && (pos_q >= PosGapHi);
    res_o.crc     = skipped ? crc_gap_d : crc_all_d;
    res_o.skipped = skipped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosFirst;
      crc_all_q  <= CrcInit;
      crc_gap_q  <= CrcInit;
      first_ff_q <= 1'b0;
      field_q    <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q      <= PosFirst;
        crc_all_q  <= CrcInit;
        crc_gap_q  <= CrcInit;
        first_ff_q <= 1'b0;
        field_q    <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        crc_all_q  <= crc_all_d;
        crc_gap_q  <= crc_gap_d;
        first_ff_q <= first_ff_d;
        field_q    <= field_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for adts_frame_crc16_top, the frame CRC-16 with header-gap rule.
// Depends on afc_pkg and the design sources; a tracker class predicts each frame's CRC.
`timescale 1ns / 100ps

module tb;
  import afc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 250;

  typedef enum int {FrmPlain, FrmHeader, FrmNearMiss} frame_kind_e;

  class frame_crc_tracker;
    logic [PosW-1:0] byte_pos;
    logic [15:0]     crc_full;
    logic [15:0]     crc_gapped;
    logic            lead_ff;
    logic            hdr_match;
    afc_res_t        pending_crcs[$];
    int              mismatches;

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos   = PosFirst;
      crc_full   = CrcInit;
      crc_gapped = CrcInit;
      lead_ff    = 1'b0;
      hdr_match  = 1'b0;
    endfunction

    // bit-serial form, data MSB first
    function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[15] ^ b[i];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ CrcPoly;
        end
      end
      return crc;
    endfunction

    function void add_byte(logic [7:0] b, logic last);
      afc_res_t        r;
      logic [PosW-1:0] p;
      p = byte_pos;
      if (p == PosFirst) begin
        lead_ff = (b == SyncByte);
      end else if (p == PosSecond) begin
        hdr_match = lead_ff && ((b & HiNibMask) == HiNibMask) && ((b & ProtAbsBit) == 8'h00);
      end
      crc_full = crc_step(crc_full, b);
      if (p != PosGapLo && p != PosGapHi) begin
        crc_gapped = crc_step(crc_gapped, b);
      end
      if (p < PosSat) begin
        byte_pos = p + 1'b1;
      end
      if (last) begin
        r.skipped = hdr_match && (p >= PosGapHi);
        r.crc     = r.skipped ? crc_gapped : crc_full;
        pending_crcs.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_crc(logic [15:0] crc, logic skipped);
      afc_res_t exp_r;
      if (pending_crcs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result: crc=%h skipped=%b", $realtime, crc, skipped);
        end
        return;
      end
      exp_r = pending_crcs.pop_front();
      if (crc !== exp_r.crc || skipped !== exp_r.skipped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch: crc exp=%h act=%h, skipped exp=%b act=%b",
                   $realtime, exp_r.crc, crc, exp_r.skipped, skipped);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] crc_value_o;
  logic        field_skipped_o;

  frame_crc_tracker tracker;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_left;
  int unsigned      cycle_count;

  adts_frame_crc16_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .crc_value_o     (crc_value_o),
    .field_skipped_o (field_skipped_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // request and result monitors
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.add_byte(data_byte_i, last_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_crc(crc_value_o, field_skipped_o);
      end
    end
  end

  // result side: random stalls plus a counted long hold
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int len, input frame_kind_e kind);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0 && kind != FrmPlain) begin
        b = SyncByte;
      end else if (i == 1 && kind == FrmHeader) begin
        b = HiNibMask | 8'($urandom_range(7) << 1);
      end else if (i == 1 && kind == FrmNearMiss) begin
        if ($urandom_range(1) == 1) begin
          b = HiNibMask | 8'($urandom_range(15)) | ProtAbsBit;
        end else begin
          b = 8'($urandom_range(14) << 4) | 8'($urandom_range(7) << 1);
        end
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic run_frames(input int byte_budget, input int max_len);
    int          sent;
    int          len;
    int unsigned pick;
    frame_kind_e kind;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        kind = FrmHeader;
      end else if (pick < 70) begin
        kind = FrmNearMiss;
      end else begin
        kind = FrmPlain;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = $urandom_range(2, 1);
      end else if (pick < 70) begin
        len = $urandom_range(11, 7);
      end else if (pick < 95) begin
        len = $urandom_range(16, 3);
      end else begin
        len = $urandom_range(40, 17);
      end
      if (len > max_len) begin
        len = $urandom_range(max_len, 1);
      end
      send_frame(len, kind);
      sent += len;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending_crcs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    last_byte_i    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-byte frames at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // header frame of exactly nine bytes: CRC over bytes 0..6
    send_byte(SyncByte, 1'b0);
    send_byte(8'hF0, 1'b0);
    for (int i = 2; i < 9; i++) begin
      send_byte(8'(8'h11 * i), i == 8);
    end
    // header pattern on a short frame is ignored
    send_byte(SyncByte, 1'b0);
    send_byte(8'hFE, 1'b1);
    // long frame, header with protection-absent bit set
    send_byte(SyncByte, 1'b0);
    send_byte(8'hFF, 1'b0);
    for (int i = 2; i < 11; i++) begin
      send_byte((i % 2 == 0) ? 8'h80 : 8'h7F, i == 10);
    end
    wait_drained();

    run_frames(250, 40);
    wait_drained();

    send_idle_pct = 64;
    run_frames(250, 40);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 64;
    run_frames(250, 40);
    wait_drained();

    send_idle_pct  = 13;
    recv_stall_pct = 13;
    run_frames(250, 40);
    wait_drained();

    // long result hold with back-to-back short frames to back up the input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HoldCycles;
    run_frames(60, 3);
    wait_drained();

    if (tracker.pending_crcs.size() != 0) begin
      $display("%0d expected results never arrived", tracker.pending_crcs.size());
    end
    if (tracker.mismatches == 0 && tracker.pending_crcs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
